/* design/accel_tilt_roll_pitch_macros.svh */
// Assertion macros for the tilt block checker.
// Depends on nothing; included by the checker file.
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ATRP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
// next-cycle implication checked outside reset
`define ATRP_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

/* design/atrp_pkg.sv */
// Shared constants, types and functions of the tilt block.
// Depends on nothing.
`default_nettype none
package atrp_pkg;
	localparam int ITERS = 32;
	localparam int ANG_W = 40;
	localparam int VEC_W = 56;
	localparam int RAD_W = 64;
	localparam int SQ_IN_W = 62;
	localparam int SQ_W = 31;
	localparam logic [ANG_W-1:0] PI_Q36 = 40'd215855012656;
	localparam logic [ANG_W-1:0] PIO4_Q36 = 40'd53963753164;
	localparam logic [3:0] REG_Z_LEVEL = 4'd0;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	// vector pair and angle handed from cell to cell
	typedef struct packed {
		vec_t px;
		vec_t py;
		ang_t ang;
		logic zero;
	} cordic_t;

	function automatic ang_t atan_q36(input int i);
		ang_t r;
		unique case (i)
			0: r = 40'sd53963753164; 1: r = 40'sd31857260018;
			2: r = 40'sd16832414004; 3: r = 40'sd8544261102;
			4: r = 40'sd4288658003; 5: r = 40'sd2146420005;
			6: r = 40'sd1073512834; 7: r = 40'sd536800937;
			8: r = 40'sd268403473; 9: r = 40'sd134202758;
			10: r = 40'sd67101507; 11: r = 40'sd33550770;
			12: r = 40'sd16775389; 13: r = 40'sd8387695;
			14: r = 40'sd4193848; 15: r = 40'sd2096924;
			16: r = 40'sd1048562; 17: r = 40'sd524281;
			18: r = 40'sd262140; 19: r = 40'sd131070;
			20: r = 40'sd65535; 21: r = 40'sd32768;
			22: r = 40'sd16384; 23: r = 40'sd8192;
			24: r = 40'sd4096; 25: r = 40'sd2048;
			26: r = 40'sd1024; 27: r = 40'sd512;
			28: r = 40'sd256; 29: r = 40'sd128;
			30: r = 40'sd64; 31: r = 40'sd32;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* design/atrp_sqrt_cell.sv */
// One digit of the restoring square root: two radicand bits per cell.
// Depends on atrp_pkg for widths.
`default_nettype none
module atrp_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [atrp_pkg::SQ_IN_W-1:0] rem_i,
	input  wire logic [atrp_pkg::SQ_W-1:0]    root_i,
	output logic      [atrp_pkg::SQ_IN_W-1:0] rem_o,
	output logic      [atrp_pkg::SQ_W-1:0]    root_o
);
	localparam int SH = 2 * (atrp_pkg::SQ_W - 1 - STEP);
	logic [atrp_pkg::SQ_IN_W+1:0] trial;
	logic [atrp_pkg::SQ_IN_W+1:0] rem_x;
	logic [atrp_pkg::SQ_W-1:0] root_t;

	// try setting this root bit
	always_comb begin
		root_t = root_i | (atrp_pkg::SQ_W'(1) << (atrp_pkg::SQ_W - 1 - STEP));
		trial = ((atrp_pkg::SQ_IN_W+2)'(root_i) << (atrp_pkg::SQ_W - STEP))
			| ((atrp_pkg::SQ_IN_W+2)'(1) << SH);
		rem_x = (atrp_pkg::SQ_IN_W+2)'(rem_i);
	end

	// keep the bit where the remainder allows it; hold while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_x >= trial) begin
				rem_o <= atrp_pkg::SQ_IN_W'(rem_x - trial);
				root_o <= root_t;
			end else begin
				rem_o <= rem_i;
				root_o <= root_i;
			end
		end
	end
endmodule
`default_nettype wire

/* design/atrp_cordic_cell.sv */
// One vectoring rotation of the arctangent chain.
// Depends on atrp_pkg for the stage type and angle table.
`default_nettype none
module atrp_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire atrp_pkg::cordic_t d_i,
	output atrp_pkg::cordic_t      d_o
);
	localparam atrp_pkg::ang_t A = atrp_pkg::atan_q36(STEP);
	atrp_pkg::vec_t sx;
	atrp_pkg::vec_t sy;

	always_comb begin
		sx = d_i.px >>> STEP;
		sy = d_i.py >>> STEP;
	end

	// rotate toward the x axis; hold while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			d_o.zero <= d_i.zero;
			if (d_i.py > 0) begin
				d_o.px <= d_i.px + sy;
				d_o.py <= d_i.py - sx;
				d_o.ang <= d_i.ang + A;
			end else begin
				d_o.px <= d_i.px - sy;
				d_o.py <= d_i.py + sx;
				d_o.ang <= d_i.ang - A;
			end
		end
	end
endmodule
`default_nettype wire

/* design/atrp_angle.sv */
// Square root, arctangent chain and degree scaling for one angle.
// Depends on atrp_pkg, atrp_sqrt_cell and atrp_cordic_cell.
`default_nettype none
module atrp_angle #(
	parameter int FRAC = 8,
	parameter int OUT_W = 17
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [atrp_pkg::SQ_IN_W-1:0] rad_i,
	input  wire logic                          neg_i,
	input  wire atrp_pkg::vec_t                num_i,
	output logic signed [OUT_W-1:0]            deg_o
);
	localparam int N = atrp_pkg::SQ_W;
	localparam int CI = atrp_pkg::ITERS;
	localparam int RW = atrp_pkg::RAD_W;
	// reciprocal of pi/4 scaled by 2^67; low product bits dropped before it
	localparam int SH = FRAC + 13;
	localparam int TS = 67 - SH;
	localparam logic [127:0] RECIP_W = (128'd1 << 67) / 128'(atrp_pkg::PIO4_Q36);
	localparam logic [31:0] RECIP = RECIP_W[31:0];
	logic [atrp_pkg::SQ_IN_W-1:0] rem [N+1];
	logic [N-1:0] root [N+1];
	logic neg_d [N+1];
	atrp_pkg::vec_t num_d [N+1];
	atrp_pkg::cordic_t c [CI+1];
	atrp_pkg::vec_t den;
	atrp_pkg::cordic_t c0;
	logic neg_s1;
	logic [atrp_pkg::ANG_W-1:0] mag_s1;
	logic [RW-1:0] prod_s2;
	logic neg_s2;
	logic [31:0] nh;
	logic [31:0] qe;
	logic [RW-1:0] p_s3;
	logic [RW-1:0] n_s3;
	logic neg_s3;
	logic [31:0] qe_s4;
	logic [RW-1:0] qd_s4;
	logic [RW-1:0] n_s4;
	logic neg_s4;
	logic [RW-1:0] q_s5;
	logic neg_s5;
	logic signed [OUT_W:0] r;

	assign rem[0] = rad_i;
	assign root[0] = '0;
	assign neg_d[0] = neg_i;
	assign num_d[0] = num_i;

	// square root cells, operands delayed alongside
	for (genvar k = 0; k < N; k++) begin : g_sq
		atrp_sqrt_cell #(.STEP(k)) u_c (
			.clk(clk), .en(en), .rem_i(rem[k]), .root_i(root[k]),
			.rem_o(rem[k+1]), .root_o(root[k+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_d[k+1] <= neg_d[k];
				num_d[k+1] <= num_d[k];
			end
		end
	end

	// turn a left-half vector by pi
	always_comb begin
		den = atrp_pkg::vec_t'(root[N]);
		c0.zero = (root[N] == '0) && (num_d[N] == '0);
		if (neg_d[N] && root[N] != '0) begin
			c0.px = den;
			c0.py = -num_d[N];
			c0.ang = (num_d[N] >= 0) ? atrp_pkg::ang_t'(atrp_pkg::PI_Q36)
				: -atrp_pkg::ang_t'(atrp_pkg::PI_Q36);
		end else begin
			c0.px = den;
			c0.py = num_d[N];
			c0.ang = '0;
		end
	end
	assign c[0] = c0;

	for (genvar k = 0; k < CI; k++) begin : g_co
		atrp_cordic_cell #(.STEP(k)) u_c (.clk(clk), .en(en), .d_i(c[k]), .d_o(c[k+1]));
	end

	// quotient estimate from the top product bits, never above the true one
	always_comb begin
		nh = 32'(prod_s2 >> SH);
		qe = 32'(p_s3 >> TS);
	end

	// scale to degrees: m*45*2^(FRAC+1)/(pi/4), split over stages
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= !c[CI].zero && c[CI].ang < 0;
			mag_s1 <= c[CI].zero ? '0 : (c[CI].ang < 0 ? -c[CI].ang : c[CI].ang);
			neg_s2 <= neg_s1;
			prod_s2 <= (RW'(mag_s1) * 64'd45) << (FRAC + 1);
			neg_s3 <= neg_s2;
			n_s3 <= prod_s2;
			p_s3 <= 64'(nh) * 64'(RECIP);
			neg_s4 <= neg_s3;
			n_s4 <= n_s3;
			qe_s4 <= qe;
			qd_s4 <= 64'(qe) * RW'(atrp_pkg::PIO4_Q36);
			// the estimate is low by at most one
			neg_s5 <= neg_s4;
			q_s5 <= 64'(qe_s4) + 64'(n_s4 - qd_s4 >= RW'(atrp_pkg::PIO4_Q36));
		end
	end

	always_comb begin
		r = (OUT_W+1)'((q_s5 + 64'd1) >> 1);
		deg_o = OUT_W'(neg_s5 ? -r : r);
	end
endmodule
`default_nettype wire

/* design/accel_tilt_roll_pitch.sv */
// Tilt angles from four samples. One request per cycle while no result is
// held; the input stage, 31 square root cells, 32 arctangent cells and
// five degree scaling stages set the depth. A held result stalls the whole
// row. Reset sets z_level to 157 and empties the valid chain.
`default_nettype none
module accel_tilt_roll_pitch #(
	parameter int SAMPLE_BITS = 12,
	parameter int ANGLE_FRAC_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raw_ch0, raw_ch1, raw_ch2, raw_ch3 from bit 0, zero fill
	input  wire logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// roll_deg, pitch_deg, diff_x, diff_y from bit 0, zero fill
	output logic [((2*ANGLE_FRAC_BITS+17+2*SAMPLE_BITS+2+7)/8)*8-1:0] m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	localparam int SB = SAMPLE_BITS;
	localparam int DW = SB + 1;
	localparam int RW = ANGLE_FRAC_BITS + 9;
	localparam int PW = ANGLE_FRAC_BITS + 8;
	localparam int PRE = (SB > 12) ? 28 - 2 * (SB - 12) : 28;
	localparam int LAT = atrp_pkg::SQ_W + atrp_pkg::ITERS + 6;
	localparam int OW = $bits(m_tdata);
	logic [15:0] z_q;
	logic en;
	logic [LAT-1:0] v_q;
	logic signed [DW-1:0] x_s1, y_s1;
	logic [15:0] z_s1;
	logic [atrp_pkg::SQ_IN_W-1:0] rr, rp;
	atrp_pkg::vec_t nr, np;
	logic signed [RW-1:0] roll;
	logic signed [PW-1:0] pitch;
	logic signed [DW-1:0] xd [LAT], yd [LAT];
	logic [SB+4:0] ax, ay;

	// configuration register
	assign pready = 1'b1;
	assign prdata = {16'd0, z_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) z_q <= 16'd157;
		else if (psel && penable && pwrite && paddr == atrp_pkg::REG_Z_LEVEL[1:0])
			z_q <= pwdata[15:0];
	end

	// the whole row advances unless a result is held
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[LAT-1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[LAT-2:0], s_tvalid};
	end

	// take the differences
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= DW'(s_tdata[SB-1:0]) - DW'(s_tdata[2*SB-1:SB]);
			y_s1 <= DW'(s_tdata[3*SB-1:2*SB]) - DW'(s_tdata[4*SB-1:3*SB]);
			z_s1 <= z_q;
		end
	end

	// radicands and numerators, 16x scaled
	always_comb begin
		ax = (SB+5)'(x_s1 < 0 ? -x_s1 : x_s1) << 4;
		ay = (SB+5)'(y_s1 < 0 ? -y_s1 : y_s1) << 4;
		rr = atrp_pkg::SQ_IN_W'((64'(z_s1) * 64'(z_s1) + 64'(ax) * 64'(ax)) << PRE);
		rp = atrp_pkg::SQ_IN_W'((64'(z_s1) * 64'(z_s1) + 64'(ay) * 64'(ay)) << PRE);
		nr = atrp_pkg::vec_t'(y_s1) <<< (4 + PRE / 2);
		np = atrp_pkg::vec_t'(x_s1) <<< (4 + PRE / 2);
	end

	atrp_angle #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(RW)) u_roll (
		.clk(clk), .en(en), .rad_i(rr), .neg_i(z_s1 == 16'd0), .num_i(nr), .deg_o(roll));
	atrp_angle #(.FRAC(ANGLE_FRAC_BITS), .OUT_W(PW)) u_pitch (
		.clk(clk), .en(en), .rad_i(rp), .neg_i(1'b0), .num_i(np), .deg_o(pitch));

	// carry differences along the row
	assign xd[0] = x_s1;
	assign yd[0] = y_s1;
	for (genvar k = 1; k < LAT; k++) begin : g_d
		always_ff @(posedge clk) begin
			if (en) begin
				xd[k] <= xd[k-1];
				yd[k] <= yd[k-1];
			end
		end
	end

	assign m_tdata = OW'({yd[LAT-1], xd[LAT-1], pitch, roll});
endmodule
`default_nettype wire

/* design/accel_tilt_roll_pitch_chk.sv */
// Port-level checker of the tilt block, bound to the top level.
// Depends on accel_tilt_roll_pitch_macros.svh.
`include "accel_tilt_roll_pitch_macros.svh"
`default_nettype none
module accel_tilt_roll_pitch_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic pready
);
	`ATRP_ASSERT_IMP(a_rdy, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`ATRP_ASSERT_IMP(a_pr, clk, arst_n, 1'b1, pready)
	`ATRP_ASSERT_NXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
endmodule
bind accel_tilt_roll_pitch accel_tilt_roll_pitch_chk u_chk (.*);
`default_nettype wire
